/* src/stt_pkg.sv */
`timescale 1ns / 1ps
package stt_pkg;

	typedef enum logic [3:0] {
		M_IDLE, M_SLASH, M_STAR, M_EQ, M_BANG, M_DOT, M_LINE, M_BLOCK,
		M_BLOCK_STAR, M_WORD, M_STRING, M_ZERO, M_NUMBER, M_HEX, M_ERROR
	} mode_t;

	typedef struct packed {
		logic ovf;
		logic digit;
		logic after_e;
		logic expo;
		logic point;
		logic hex;
	} nflags_t;

	localparam logic [4:0] K_END     = 5'd0;
	localparam logic [4:0] K_ERROR   = 5'd1;
	localparam logic [4:0] K_NATURAL = 5'd2;
	localparam logic [4:0] K_REAL    = 5'd3;
	localparam logic [4:0] K_STRING  = 5'd4;
	localparam logic [4:0] K_IDENT   = 5'd5;
	localparam logic [4:0] K_TRUE    = 5'd6;
	localparam logic [4:0] K_FALSE   = 5'd7;
	localparam logic [4:0] K_FN      = 5'd8;
	localparam logic [4:0] K_VAR     = 5'd9;
	localparam logic [4:0] K_IF      = 5'd10;
	localparam logic [4:0] K_ELSE    = 5'd11;
	localparam logic [4:0] K_RETURN  = 5'd12;
	localparam logic [4:0] K_EQEQ    = 5'd13;
	localparam logic [4:0] K_NOTEQ   = 5'd14;
	localparam logic [4:0] K_PLUS    = 5'd15;
	localparam logic [4:0] K_MINUS   = 5'd16;
	localparam logic [4:0] K_STAR    = 5'd17;
	localparam logic [4:0] K_SLASH   = 5'd18;
	localparam logic [4:0] K_ASSIGN  = 5'd19;
	localparam logic [4:0] K_NOT     = 5'd20;
	localparam logic [4:0] K_LT      = 5'd21;
	localparam logic [4:0] K_GT      = 5'd22;
	localparam logic [4:0] K_LPAREN  = 5'd23;
	localparam logic [4:0] K_RPAREN  = 5'd24;
	localparam logic [4:0] K_LBRACE  = 5'd25;
	localparam logic [4:0] K_RBRACE  = 5'd26;
	localparam logic [4:0] K_COMMA   = 5'd27;
	localparam logic [4:0] K_SEMI    = 5'd28;

	localparam logic [3:0] E_NONE        = 4'd0;
	localparam logic [3:0] E_BAD_CHAR    = 4'd1;
	localparam logic [3:0] E_OPEN_BLOCK  = 4'd2;
	localparam logic [3:0] E_STRAY_CLOSE = 4'd3;
	localparam logic [3:0] E_LEAD_ZERO   = 4'd4;
	localparam logic [3:0] E_POINT       = 4'd5;
	localparam logic [3:0] E_SECOND_EXP  = 4'd6;
	localparam logic [3:0] E_NUM_CHAR    = 4'd7;
	localparam logic [3:0] E_RANGE       = 4'd8;
	localparam logic [3:0] E_MALFORMED   = 4'd9;
	localparam logic [3:0] E_ESCAPE      = 4'd10;
	localparam logic [3:0] E_OPEN_STRING = 4'd11;
	localparam logic [3:0] E_PUNCT       = 4'd12;

	typedef struct packed {
		logic [4:0]  token_kind;
		logic [3:0]  error_code;
		logic [23:0] start_pos;
		logic [23:0] end_pos;
		logic [63:0] natural_value;
		logic        last_of_item;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} push_t;

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_punct(input logic [7:0] c);
		return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
			(c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
	endfunction

	function automatic logic [4:0] hex_val(input logic [7:0] c);
		logic [4:0] v;
		v = 5'h10;
		if (is_digit(c)) v = {1'b0, 4'(c - "0")};
		else if (c >= "a" && c <= "f") v = {1'b0, 4'(c - "a" + 8'd10)};
		else if (c >= "A" && c <= "F") v = {1'b0, 4'(c - "A" + 8'd10)};
		return v;
	endfunction

	// Kind of a single-character operator, K_END when the byte is none.
	function automatic logic [4:0] single_op(input logic [7:0] c);
		logic [4:0] k;
		case (c)
			"+": k = K_PLUS;
			"-": k = K_MINUS;
			"<": k = K_LT;
			">": k = K_GT;
			"(": k = K_LPAREN;
			")": k = K_RPAREN;
			"{": k = K_LBRACE;
			"}": k = K_RBRACE;
			",": k = K_COMMA;
			";": k = K_SEMI;
			default: k = K_END;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] word_kind(input logic [47:0] wc, input logic [2:0] wl);
		logic [4:0] k;
		k = K_IDENT;
		if (wl == 3'd4 && wc == 48'h0000_7472_7565) k = K_TRUE;
		else if (wl == 3'd5 && wc == 48'h0066_616C_7365) k = K_FALSE;
		else if (wl == 3'd2 && wc == 48'h0000_0000_666E) k = K_FN;
		else if (wl == 3'd3 && wc == 48'h0000_0076_6172) k = K_VAR;
		else if (wl == 3'd2 && wc == 48'h0000_0000_6966) k = K_IF;
		else if (wl == 3'd4 && wc == 48'h0000_656C_7365) k = K_ELSE;
		else if (wl == 3'd6 && wc == 48'h7265_7475_726E) k = K_RETURN;
		return k;
	endfunction

	function automatic result_t mk(input logic [4:0] kind, input logic [3:0] code,
		input logic [23:0] b, input logic [23:0] e, input logic [63:0] v);
		result_t r;
		r.token_kind    = kind;
		r.error_code    = code;
		r.start_pos     = b;
		r.end_pos       = e;
		r.natural_value = v;
		r.last_of_item  = 1'b0;
		return r;
	endfunction

endpackage

/* src/stt_text_if.sv */
`timescale 1ns / 1ps
interface stt_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       end_of_input;

	modport source(output valid, output byte_in, output end_of_input, input ready);
	modport sink(input valid, input byte_in, input end_of_input, output ready);
endinterface

/* src/stt_token_if.sv */
`timescale 1ns / 1ps
interface stt_token_if;
	logic        valid;
	logic        ready;
	logic [4:0]  token_kind;
	logic [3:0]  error_code;
	logic [23:0] start_pos;
	logic [23:0] end_pos;
	logic [63:0] natural_value;
	logic        last_of_item;

	modport source(output valid, output token_kind, output error_code, output start_pos,
		output end_pos, output natural_value, output last_of_item, input ready);
	modport sink(input valid, input token_kind, input error_code, input start_pos,
		input end_pos, input natural_value, input last_of_item, output ready);
endinterface

/* src/stt_lexer.sv */
`timescale 1ns / 1ps
module stt_lexer #(
	parameter int POS_BITS = 24
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic [7:0]    byte_in,
	input  logic          end_of_input,
	output stt_pkg::push_t push
);
	import stt_pkg::*;

	mode_t                mode_q, mode_n;
	logic [POS_BITS-1:0]  pos_q, pos_n, ts_q, ts_n;
	logic [47:0]          wc_q, wc_n;
	logic [2:0]           wl_q, wl_n;
	nflags_t              fl_q, fl_n;
	logic [63:0]          acc_q, acc_n;

	result_t              res [2];
	logic [1:0]           cnt;
	logic                 restart, do_num, do_fin, skip;
	logic [POS_BITS-1:0]  p1, ts1, ts2;
	logic [23:0]          po, p1o, tso, ts1o, ts2o;
	logic [67:0]          acc10;
	logic [4:0]           hv, op;
	logic [4:0]           fin_kind;
	logic [3:0]           fin_code;
	logic [63:0]          fin_val;

	function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] p);
		return (&p) ? p : p + 1'b1;
	endfunction

	function automatic logic [23:0] clamp(input logic [POS_BITS-1:0] p);
		logic [47:0] w;
		w = 48'(p);
		return (|w[47:24]) ? 24'hFFFFFF : w[23:0];
	endfunction

	always_comb begin
		p1   = sat_inc(pos_q);
		ts1  = sat_inc(ts_q);
		ts2  = sat_inc(ts1);
		po   = clamp(pos_q);
		p1o  = clamp(p1);
		tso  = clamp(ts_q);
		ts1o = clamp(ts1);
		ts2o = clamp(ts2);
		acc10 = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + 68'(byte_in[3:0]);
		hv   = hex_val(byte_in);
		op   = single_op(byte_in);

		// Closing a number: hex needs a digit, an exponent needs a digit.
		fin_val = 64'd0;
		if (fl_q.hex) begin
			if (!fl_q.digit) begin
				fin_kind = K_ERROR; fin_code = E_MALFORMED;
			end else if (fl_q.ovf) begin
				fin_kind = K_ERROR; fin_code = E_RANGE;
			end else begin
				fin_kind = K_NATURAL; fin_code = E_NONE; fin_val = acc_q;
			end
		end else if (fl_q.point || fl_q.expo) begin
			if (fl_q.expo && !fl_q.digit) begin
				fin_kind = K_ERROR; fin_code = E_MALFORMED;
			end else begin
				fin_kind = K_REAL; fin_code = E_NONE;
			end
		end else if (fl_q.ovf) begin
			fin_kind = K_ERROR; fin_code = E_RANGE;
		end else begin
			fin_kind = K_NATURAL; fin_code = E_NONE; fin_val = acc_q;
		end
	end

	always_comb begin
		mode_n = mode_q; pos_n = pos_q; ts_n = ts_q; wc_n = wc_q; wl_n = wl_q;
		fl_n = fl_q; acc_n = acc_q;
		res[0] = mk(K_END, E_NONE, 24'd0, 24'd0, 64'd0);
		res[1] = res[0];
		cnt = 2'd0;
		restart = 1'b0; do_num = 1'b0; do_fin = 1'b0; skip = 1'b0;

		if (end_of_input) begin
			unique case (mode_q)
				M_SLASH: begin res[0] = mk(K_SLASH, E_NONE, tso, ts1o, 64'd0); cnt = 2'd1; end
				M_STAR: begin res[0] = mk(K_STAR, E_NONE, tso, ts1o, 64'd0); cnt = 2'd1; end
				M_EQ: begin res[0] = mk(K_ASSIGN, E_NONE, tso, ts1o, 64'd0); cnt = 2'd1; end
				M_BANG: begin res[0] = mk(K_NOT, E_NONE, tso, ts1o, 64'd0); cnt = 2'd1; end
				M_DOT: begin
					res[0] = mk(K_ERROR, E_PUNCT, tso, ts1o, 64'd0); cnt = 2'd1;
				end
				M_BLOCK, M_BLOCK_STAR: begin
					res[0] = mk(K_ERROR, E_OPEN_BLOCK, tso, ts2o, 64'd0); cnt = 2'd1;
				end
				M_WORD: begin
					res[0] = mk(word_kind(wc_q, wl_q), E_NONE, tso, po, 64'd0); cnt = 2'd1;
				end
				M_STRING: begin
					res[0] = mk(K_ERROR, E_OPEN_STRING, tso, ts1o, 64'd0); cnt = 2'd1;
				end
				M_ZERO, M_NUMBER, M_HEX: begin
					res[0] = mk(fin_kind, fin_code, tso, po, fin_val); cnt = 2'd1;
				end
				default: ;
			endcase
			res[cnt[0]] = mk(K_END, E_NONE, po, po, 64'd0);
			cnt = cnt + 2'd1;
			mode_n = M_IDLE; pos_n = '0; ts_n = '0; wc_n = '0; wl_n = '0;
			fl_n = '0; acc_n = '0;
		end else begin
			pos_n = p1;
			unique case (mode_q)
				M_ERROR: ;
				M_SLASH: begin
					if (byte_in == "/") mode_n = M_LINE;
					else if (byte_in == "*") mode_n = M_BLOCK;
					else begin
						res[0] = mk(K_SLASH, E_NONE, tso, ts1o, 64'd0); cnt = 2'd1;
						restart = 1'b1;
					end
				end
				M_STAR: begin
					if (byte_in == "/") begin
						res[0] = mk(K_ERROR, E_STRAY_CLOSE, tso, ts2o, 64'd0); cnt = 2'd1;
						mode_n = M_ERROR;
					end else begin
						res[0] = mk(K_STAR, E_NONE, tso, ts1o, 64'd0); cnt = 2'd1;
						restart = 1'b1;
					end
				end
				M_EQ, M_BANG: begin
					if (byte_in == "=") begin
						res[0] = mk((mode_q == M_EQ) ? K_EQEQ : K_NOTEQ, E_NONE, tso, p1o, 64'd0);
						cnt = 2'd1;
						mode_n = M_IDLE;
					end else begin
						res[0] = mk((mode_q == M_EQ) ? K_ASSIGN : K_NOT, E_NONE, tso, ts1o,
							64'd0);
						cnt = 2'd1;
						restart = 1'b1;
					end
				end
				M_DOT: begin
					if (is_digit(byte_in)) begin
						fl_n = '0; fl_n.point = 1'b1; acc_n = '0; mode_n = M_NUMBER;
					end else begin
						res[0] = mk(K_ERROR, E_PUNCT, tso, ts1o, 64'd0); cnt = 2'd1;
						mode_n = M_ERROR;
					end
				end
				M_LINE: if (byte_in == 8'h0A) mode_n = M_IDLE;
				M_BLOCK: if (byte_in == "*") mode_n = M_BLOCK_STAR;
				M_BLOCK_STAR: begin
					if (byte_in == "/") mode_n = M_IDLE;
					else if (byte_in != "*") mode_n = M_BLOCK;
				end
				M_WORD: begin
					if (is_alpha(byte_in) || is_digit(byte_in) || byte_in == "_") begin
						if (wl_q < 3'd6) wc_n = {wc_q[39:0], byte_in};
						if (wl_q < 3'd7) wl_n = wl_q + 3'd1;
					end else begin
						res[0] = mk(word_kind(wc_q, wl_q), E_NONE, tso, po, 64'd0); cnt = 2'd1;
						restart = 1'b1;
					end
				end
				M_STRING: begin
					if (byte_in == "\"") begin
						res[0] = mk(K_STRING, E_NONE, tso, p1o, 64'd0); cnt = 2'd1;
						mode_n = M_IDLE;
					end else if (byte_in == "\\") begin
						res[0] = mk(K_ERROR, E_ESCAPE, po, p1o, 64'd0); cnt = 2'd1;
						mode_n = M_ERROR;
					end
				end
				M_ZERO: begin
					if (is_digit(byte_in)) begin
						res[0] = mk(K_ERROR, E_LEAD_ZERO, tso, ts1o, 64'd0); cnt = 2'd1;
						mode_n = M_ERROR;
					end else if (byte_in == "x" || byte_in == "X") begin
						fl_n = '0; fl_n.hex = 1'b1; acc_n = '0; mode_n = M_HEX;
					end else begin
						mode_n = M_NUMBER; do_num = 1'b1;
					end
				end
				M_NUMBER: do_num = 1'b1;
				M_HEX: begin
					if (byte_in == ".") begin
						res[0] = mk(K_ERROR, E_POINT, po, p1o, 64'd0); cnt = 2'd1;
						mode_n = M_ERROR;
					end else if (!hv[4]) begin
						fl_n.digit = 1'b1;
						if (!fl_q.ovf) begin
							if (|acc_q[63:60]) fl_n.ovf = 1'b1;
							else acc_n = {acc_q[59:0], hv[3:0]};
						end
					end else if (is_space(byte_in) || is_punct(byte_in)) do_fin = 1'b1;
					else begin
						res[0] = mk(K_ERROR, E_NUM_CHAR, po, p1o, 64'd0); cnt = 2'd1;
						mode_n = M_ERROR;
					end
				end
				default: restart = 1'b1;
			endcase

			// Decimal or real number body.
			if (do_num) begin
				if (fl_q.after_e) begin
					fl_n.after_e = 1'b0;
					if (byte_in == "-") skip = 1'b1;
				end
				if (!skip) begin
					if (byte_in == ".") begin
						if (fl_q.point || fl_q.expo) begin
							res[0] = mk(K_ERROR, E_POINT, po, p1o, 64'd0); cnt = 2'd1;
							mode_n = M_ERROR;
						end else fl_n.point = 1'b1;
					end else if (byte_in == "e" || byte_in == "E") begin
						if (fl_q.expo) begin
							res[0] = mk(K_ERROR, E_SECOND_EXP, po, p1o, 64'd0); cnt = 2'd1;
							mode_n = M_ERROR;
						end else begin
							fl_n.expo = 1'b1; fl_n.after_e = 1'b1;
						end
					end else if (is_space(byte_in) || is_punct(byte_in)) begin
						do_fin = 1'b1;
					end else if (is_digit(byte_in)) begin
						if (fl_q.expo) fl_n.digit = 1'b1;
						else if (!(fl_q.point || fl_q.ovf)) begin
							if (|acc10[67:64]) fl_n.ovf = 1'b1;
							else acc_n = acc10[63:0];
						end
					end else begin
						res[0] = mk(K_ERROR, E_NUM_CHAR, po, p1o, 64'd0); cnt = 2'd1;
						mode_n = M_ERROR;
					end
				end
			end

			if (do_fin) begin
				res[0] = mk(fin_kind, fin_code, tso, po, fin_val); cnt = 2'd1;
				if (fin_kind == K_ERROR) mode_n = M_ERROR;
				else restart = 1'b1;
			end

			// Fresh start from between tokens.
			if (restart) begin
				mode_n = M_IDLE;
				ts_n = pos_q;
				if (is_space(byte_in)) mode_n = M_IDLE;
				else if (byte_in == "/") mode_n = M_SLASH;
				else if (byte_in == "*") mode_n = M_STAR;
				else if (byte_in == "=") mode_n = M_EQ;
				else if (byte_in == "!") mode_n = M_BANG;
				else if (is_digit(byte_in)) begin
					fl_n = '0;
					acc_n = 64'(byte_in[3:0]);
					mode_n = (byte_in == "0") ? M_ZERO : M_NUMBER;
				end else if (byte_in == ".") mode_n = M_DOT;
				else if (byte_in == "_" || is_alpha(byte_in)) begin
					wc_n = {40'd0, byte_in}; wl_n = 3'd1; mode_n = M_WORD;
				end else if (byte_in == "\"") mode_n = M_STRING;
				else if (op != K_END) begin
					res[cnt[0]] = mk(op, E_NONE, po, p1o, 64'd0); cnt = cnt + 2'd1;
				end else begin
					res[cnt[0]] = mk(K_ERROR, is_punct(byte_in) ? E_PUNCT : E_BAD_CHAR, po, p1o,
						64'd0);
					cnt = cnt + 2'd1;
					mode_n = M_ERROR;
				end
			end
		end

		if (cnt == 2'd1) res[0].last_of_item = 1'b1;
		res[1].last_of_item = 1'b1;
		push.count = step ? cnt : 2'd0;
		push.r0 = res[0];
		push.r1 = res[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			pos_q  <= '0;
			ts_q   <= '0;
			wc_q   <= '0;
			wl_q   <= '0;
			fl_q   <= '0;
			acc_q  <= '0;
		end else if (step) begin
			mode_q <= mode_n;
			pos_q  <= pos_n;
			ts_q   <= ts_n;
			wc_q   <= wc_n;
			wl_q   <= wl_n;
			fl_q   <= fl_n;
			acc_q  <= acc_n;
		end
	end
endmodule

/* src/stt_result_fifo.sv */
`timescale 1ns / 1ps
module stt_result_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  stt_pkg::push_t  push,
	input  logic            pop,
	output logic            has_room,
	output logic            not_empty,
	output stt_pkg::result_t head
);
	import stt_pkg::*;

	result_t    mem_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;

	assign has_room  = cnt_q <= 3'd2;
	assign not_empty = cnt_q != 3'd0;
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) mem_q[wr_q] <= push.r0;
		if (push.count == 2'd2) mem_q[wr_q + 2'd1] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + push.count;
			rd_q  <= rd_q + 2'(pop);
			cnt_q <= cnt_q + 3'(push.count) - 3'(pop);
		end
	end
endmodule

/* src/source_text_tokenizer.sv */
`timescale 1ns / 1ps
// Channel  Direction  Payload
// text     in         byte_in, end_of_input
// tokens   out        token_kind, error_code, start_pos, end_pos, natural_value,
//                     last_of_item
//
// Each accepted byte is held in an input register and is then lexed against the lexer
// state, giving zero, one or two tokens that enter a four-entry result queue. A new
// byte can be taken every cycle while the queue has room for two more tokens; the two
// tokens of one item leave the queue one per token transfer.
// Reset clears the lexer to between tokens at position zero and empties the queue.
// A stall on the token side fills the queue and then holds the input register.
module source_text_tokenizer #(
	parameter int POS_BITS = 24
) (
	input  logic  clk,
	input  logic  arst_n,
	stt_text_if.sink    text,
	stt_token_if.source tokens
);
	import stt_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eoi_s1;
	logic       advance;
	logic       has_room;
	logic       not_empty;
	push_t      push;
	result_t    head;

	// The held byte is lexed when the queue can absorb two tokens.
	assign advance    = valid_s1 && has_room;
	assign text.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			byte_s1 <= text.byte_in;
			eoi_s1  <= text.end_of_input;
		end
	end

	stt_lexer #(.POS_BITS(POS_BITS)) u_lexer (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.byte_in      (byte_s1),
		.end_of_input (eoi_s1),
		.push         (push)
	);

	stt_result_fifo u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (tokens.valid && tokens.ready),
		.has_room  (has_room),
		.not_empty (not_empty),
		.head      (head)
	);

	// Each token transfer pops the head of the queue.
	assign tokens.valid         = not_empty;
	assign tokens.token_kind    = head.token_kind;
	assign tokens.error_code    = head.error_code;
	assign tokens.start_pos     = head.start_pos;
	assign tokens.end_pos       = head.end_pos;
	assign tokens.natural_value = head.natural_value;
	assign tokens.last_of_item  = head.last_of_item;
endmodule
